@@ rtl/core/vaa_pkg.sv @@
// ----------------------------------------------------------------------------
// vaa_pkg - shared types and constants for the vector angle unit
// Pipeline depth, angle table, output scaling and the sideband flag type.
// ----------------------------------------------------------------------------
package vaa_pkg;

  // number of cordic iterations, one pipeline stage each (at most 32)
  localparam int CORDIC_STEPS = 24;

  // 2*pi in unsigned q3.28, rounded half up
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // half a turn as a 32-bit binary angle
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a binary angle, 2^32 is one full turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
    32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
  };

  // per-item flags carried alongside the angle path
  typedef struct packed {
    logic zero_vector;  // a or b is all zero
    logic null_angle;   // cross and dot terms are both zero
  } vaa_flags_t;

endpackage

@@ rtl/core/vaa_cordic.sv @@
// ----------------------------------------------------------------------------
// vaa_cordic - unrolled vectoring cordic
// One iteration per register stage; stages advance independently, so bubbles
// collapse and an output stall holds each item whose next stage is full.
// ----------------------------------------------------------------------------
module vaa_cordic
  import vaa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_x,
  input  logic signed [63:0] in_y,
  input  logic        [31:0] in_ang,
  input  vaa_flags_t         in_flags,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [31:0] out_ang,
  output vaa_flags_t         out_flags
);

  logic [CORDIC_STEPS-1:0] valid;
  logic [CORDIC_STEPS:0]   en;
  logic signed [63:0]      x_q   [CORDIC_STEPS];
  logic signed [63:0]      y_q   [CORDIC_STEPS];
  logic        [31:0]      ang_q [CORDIC_STEPS];
  vaa_flags_t              flags_q [CORDIC_STEPS];

  assign en[CORDIC_STEPS] = out_ready;
  assign in_ready         = en[0];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [63:0] x_in, y_in, x_next, y_next;
    logic        [31:0] ang_in, ang_next;
    vaa_flags_t         flags_in;
    logic               valid_in;

    // stage input: ports for the first iteration, previous stage otherwise
    if (k == 0) begin : g_first
      assign x_in     = in_x;
      assign y_in     = in_y;
      assign ang_in   = in_ang;
      assign flags_in = in_flags;
      assign valid_in = in_valid;
    end else begin : g_rest
      assign x_in     = x_q[k-1];
      assign y_in     = y_q[k-1];
      assign ang_in   = ang_q[k-1];
      assign flags_in = flags_q[k-1];
      assign valid_in = valid[k-1];
    end

    // a stage loads when it is empty or its content moves on
    assign en[k] = !valid[k] || en[k+1];

    // rotate toward the x axis by atan(2^-k)
    always_comb begin
      if (y_in[63]) begin
        x_next   = x_in - (y_in >>> k);
        y_next   = y_in + (x_in >>> k);
        ang_next = ang_in - ATAN_TURNS[k];
      end else begin
        x_next   = x_in + (y_in >>> k);
        y_next   = y_in - (x_in >>> k);
        ang_next = ang_in + ATAN_TURNS[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en[k]) begin
        valid[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_q[k]     <= x_next;
        y_q[k]     <= y_next;
        ang_q[k]   <= ang_next;
        flags_q[k] <= flags_in;
      end
    end
  end

  assign out_valid = valid[CORDIC_STEPS-1];
  assign out_ang   = ang_q[CORDIC_STEPS-1];
  assign out_flags = flags_q[CORDIC_STEPS-1];

endmodule

@@ rtl/core/vector_angle_atan2_unit.sv @@
// ----------------------------------------------------------------------------
// vector_angle_atan2_unit - planar angle from base vector b to vector a
// Forms the exact cross and dot terms, normalizes them, runs a vectoring
// cordic and scales the binary angle to unsigned q3.28 radians in [0, 2*pi].
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_ready  | a_x a_y a_z b_x b_y b_z (signed q16.16)
//   out     | out_valid / out_ready| angle_rad (q3.28), zero_vector
//
// one beat in and one beat out per cycle when the output is taken
// the pipeline has 7 front stages, CORDIC_STEPS cordic stages and 2 scaling stages
// each stage holds its item only while the next one is full and stalled,
// so empty stages fill up behind a stalled output
// rst is synchronous and clears only the stage valid bits
// ----------------------------------------------------------------------------
module vector_angle_atan2_unit
  import vaa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [30:0] angle_rad,
  output logic               zero_vector
);

  // leading zeros of a nonzero byte
  function automatic logic [2:0] lead_zeros8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  // stage enables, back to front
  logic en1, en2, en3, en4, en5, en6, en7, en_m, en_o;
  logic cd_in_ready, cd_valid;
  logic [31:0] cd_ang;
  vaa_flags_t  cd_flags;

  // stage 1: products and zero detect
  logic               s1_valid;
  logic signed [63:0] s1_bxay, s1_byax, s1_axbx, s1_ayby, s1_azbz;
  vaa_flags_t         s1_flags;
  // stage 2: cross and dot sums
  logic               s2_valid;
  logic signed [64:0] s2_z, s2_d;
  vaa_flags_t         s2_flags;
  // stage 3: magnitudes and start angle
  logic               s3_valid;
  logic        [63:0] s3_mx, s3_my;
  logic               s3_yneg;
  logic        [31:0] s3_ang;
  vaa_flags_t         s3_flags;
  // stage 4: per-byte leading zero codes
  logic               s4_valid;
  logic        [63:0] s4_mx, s4_my;
  logic        [7:0]  s4_nz;
  logic        [2:0]  s4_lz [8];
  logic               s4_yneg;
  logic        [31:0] s4_ang;
  vaa_flags_t         s4_flags;
  // stage 5: total shift
  logic               s5_valid;
  logic        [63:0] s5_mx, s5_my;
  logic        [6:0]  s5_shift;
  logic               s5_yneg;
  logic        [31:0] s5_ang;
  vaa_flags_t         s5_flags;
  // stage 6: coarse shift by whole bytes
  logic               s6_valid;
  logic        [66:0] s6_mx, s6_my;
  logic        [2:0]  s6_fine;
  logic               s6_yneg;
  logic        [31:0] s6_ang;
  vaa_flags_t         s6_flags;
  // stage 7: fine shift and signed cordic start vector
  logic               s7_valid;
  logic signed [63:0] s7_x, s7_y;
  logic        [31:0] s7_ang;
  vaa_flags_t         s7_flags;
  // scaling stages
  logic               m_valid;
  logic        [62:0] m_prod;
  vaa_flags_t         m_flags;
  logic        [63:0] rounded;

  logic signed [64:0] z_abs, d_abs;
  logic        [63:0] m_or;
  logic        [6:0]  lz_total;
  logic        [66:0] fx, fy;
  logic        [63:0] fx64, fy64;

  // enable chain: a stage loads when empty or when its item moves on
  assign en_o     = !out_valid || out_ready;
  assign en_m     = !m_valid || en_o;
  assign en7      = !s7_valid || cd_in_ready;
  assign en6      = !s6_valid || en7;
  assign en5      = !s5_valid || en6;
  assign en4      = !s4_valid || en5;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  s1_valid  <= in_valid;
      if (en2)  s2_valid  <= s1_valid;
      if (en3)  s3_valid  <= s2_valid;
      if (en4)  s4_valid  <= s3_valid;
      if (en5)  s5_valid  <= s4_valid;
      if (en6)  s6_valid  <= s5_valid;
      if (en7)  s7_valid  <= s6_valid;
      if (en_m) m_valid   <= cd_valid;
      if (en_o) out_valid <= m_valid;
    end
  end

  // stage 1: five exact 32x32 products
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_bxay              <= a_y * b_x;
      s1_byax              <= b_y * a_x;
      s1_axbx              <= a_x * b_x;
      s1_ayby              <= a_y * b_y;
      s1_azbz              <= a_z * b_z;
      s1_flags.zero_vector <= (a_x == '0 && a_y == '0 && a_z == '0) ||
                              (b_x == '0 && b_y == '0 && b_z == '0);
      s1_flags.null_angle  <= 1'b0;
    end
  end

  // stage 2: cross term z and dot product d, 65-bit exact
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_z     <= 65'(s1_bxay) - 65'(s1_byax);
      s2_d     <= 65'(s1_axbx) + 65'(s1_ayby) + 65'(s1_azbz);
      s2_flags <= s1_flags;
    end
  end

  // stage 3: magnitudes, y sign after a half-turn fold when d is negative
  assign z_abs = s2_z[64] ? -s2_z : s2_z;
  assign d_abs = s2_d[64] ? -s2_d : s2_d;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_mx                <= d_abs[63:0];
      s3_my                <= z_abs[63:0];
      s3_yneg              <= s2_z[64] ^ s2_d[64];
      s3_ang               <= s2_d[64] ? HALF_TURN : '0;
      s3_flags.zero_vector <= s2_flags.zero_vector;
      s3_flags.null_angle  <= (s2_z == '0) && (s2_d == '0);
    end
  end

  // stage 4: leading zero code for each byte of the larger magnitude
  assign m_or = s3_mx | s3_my;

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int g = 0; g < 8; g++) begin
        s4_nz[g] <= |m_or[8*g +: 8];
        s4_lz[g] <= lead_zeros8(m_or[8*g +: 8]);
      end
      s4_mx    <= s3_mx;
      s4_my    <= s3_my;
      s4_yneg  <= s3_yneg;
      s4_ang   <= s3_ang;
      s4_flags <= s3_flags;
    end
  end

  // stage 5: leading zeros of the whole word from the top nonzero byte
  always_comb begin
    lz_total = 7'd64;
    for (int g = 0; g < 8; g++) begin
      if (s4_nz[g]) lz_total = 7'(8 * (7 - g)) + {4'b0000, s4_lz[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_mx    <= s4_mx;
      s5_my    <= s4_my;
      s5_shift <= lz_total;
      s5_yneg  <= s4_yneg;
      s5_ang   <= s4_ang;
      s5_flags <= s4_flags;
    end
  end

  // stage 6: coarse left shift; three guard bits allow the truncating
  // right shift when the larger magnitude has more than 61 bits
  always_ff @(posedge clk) begin
    if (en6) begin
      s6_mx    <= {s5_mx, 3'b000} << {s5_shift[6:3], 3'b000};
      s6_my    <= {s5_my, 3'b000} << {s5_shift[6:3], 3'b000};
      s6_fine  <= s5_shift[2:0];
      s6_yneg  <= s5_yneg;
      s6_ang   <= s5_ang;
      s6_flags <= s5_flags;
    end
  end

  // stage 7: fine shift; the top bit lands at bit 60 of the start vector
  assign fx   = s6_mx << s6_fine;
  assign fy   = s6_my << s6_fine;
  assign fx64 = {3'b000, fx[66:6]};
  assign fy64 = {3'b000, fy[66:6]};

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_x     <= signed'(fx64);
      s7_y     <= s6_yneg ? -signed'(fy64) : signed'(fy64);
      s7_ang   <= s6_ang;
      s7_flags <= s6_flags;
    end
  end

  vaa_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s7_valid),
    .in_ready  (cd_in_ready),
    .in_x      (s7_x),
    .in_y      (s7_y),
    .in_ang    (s7_ang),
    .in_flags  (s7_flags),
    .out_valid (cd_valid),
    .out_ready (en_m),
    .out_ang   (cd_ang),
    .out_flags (cd_flags)
  );

  // binary angle times 2*pi in q3.28
  always_ff @(posedge clk) begin
    if (en_m) begin
      m_prod  <= {31'b0, cd_ang} * {32'b0, TWO_PI_Q28};
      m_flags <= cd_flags;
    end
  end

  // round half up, drop the 32 turn fraction bits
  assign rounded = {1'b0, m_prod} + 64'h0000_0000_8000_0000;

  always_ff @(posedge clk) begin
    if (en_o) begin
      angle_rad   <= (m_flags.zero_vector || m_flags.null_angle) ? '0 : rounded[62:32];
      zero_vector <= m_flags.zero_vector;
    end
  end

  // a zero vector always reports a zero angle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> angle_rad == '0)
    else $error("zero vector beat with nonzero angle");

  // the angle never reaches past one turn
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_rad <= TWO_PI_Q28)
    else $error("angle out of range");

  // an all-zero first vector is flagged in the first stage
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && a_x == '0 && a_y == '0 && a_z == '0
      |=> s1_valid && s1_flags.zero_vector)
    else $error("zero vector not flagged");

  // a held scaling stage keeps its product
  assert property (@(posedge clk) disable iff (rst)
    m_valid && !en_m |=> m_valid && $stable(m_prod))
    else $error("stalled scaling stage changed");

  // the cordic never presents a beat that the scaling stage drops
  assert property (@(posedge clk) disable iff (rst)
    cd_valid && !en_m |=> cd_valid && $stable(cd_ang))
    else $error("cordic output lost under stall");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench for vector_angle_atan2_unit
// Sends a short table of corner-case vector pairs, then about two thousand
// random pairs shaped toward zero vectors, null angles and flat xy cases.
// Every result beat is checked field by field against a bit-exact angle
// predictor or a typed-in result. Sender bursts, receiver stall patterns and
// two long receiver hold-offs exercise the pipeline's flow control.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM = 2000;
  localparam int HOLD_FIRST_AT = 700;
  localparam int HOLD_SECOND_AT = 1500;
  localparam int PAUSE_AT = 1100;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTED = 40;
  localparam int ANGLE_STEPS = 24;
  localparam int NORM_WIDTH = 61;
  localparam logic [63:0] FULL_TURN_Q28 = 64'd1686629713;
  localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] ATAN_STEP_TURNS [32] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
    32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
  };

  typedef struct packed {
    logic [30:0] angle;
    logic        zero;
  } angle_result_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } signed_mag_t;

  // one vector pair, with the result typed in where it is obvious
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic               known;
    logic [30:0]        angle;
    logic               zero;
  } pair_row_t;

  typedef enum int {COMP_FULL, COMP_SMALL, COMP_CORNER} comp_kind_t;
  typedef enum int {TAKE_ALL, TAKE_HALF, TAKE_EVERY_FOURTH, TAKE_MOST} stall_pattern_t;

  // directed pairs: zero vectors, null angles, axis cases and extremes
  localparam pair_row_t DIRECTED_PAIRS [N_DIRECTED] = '{
    '{0, 0, 0, 65536, 131072, 196608, 1, 0, 1},
    '{65536, 0, 0, 0, 0, 0, 1, 0, 1},
    '{0, 0, 0, 0, 0, 0, 1, 0, 1},
    '{MIN_Q, MIN_Q, MIN_Q, 0, 0, 0, 1, 0, 1},
    '{65536, 0, 0, 0, 0, 65536, 1, 0, 0},
    '{1, 2, 5, 2, 4, -2, 1, 0, 0},
    '{MAX_Q, 0, 0, 0, 0, MIN_Q, 1, 0, 0},
    '{65536, 0, 0, 65536, 0, 0, 0, 0, 0},
    '{0, 65536, 0, 65536, 0, 0, 0, 0, 0},
    '{-65536, 0, 0, 65536, 0, 0, 0, 0, 0},
    '{0, -65536, 0, 65536, 0, 0, 0, 0, 0},
    '{-1, -1, 0, 1, 0, 0, 0, 0, 0},
    '{1, -1, 0, 1, 0, 0, 0, 0, 0},
    '{MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 0, 0, 0},
    '{MAX_Q, MAX_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q, 0, 0, 0},
    '{MAX_Q, 0, 0, 0, MAX_Q, 0, 0, 0, 0},
    '{MIN_Q, MAX_Q, 0, MAX_Q, MIN_Q, 0, 0, 0, 0},
    '{0, 0, MAX_Q, 0, 0, MIN_Q, 0, 0, 0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
      32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 0},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 0, 0, 0},
    '{1, 0, 0, MAX_Q, 1, 0, 0, 0, 0},
    '{-1, 0, 0, 0, -1, 0, 0, 0, 0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] a_x = '0;
  logic signed [31:0] a_y = '0;
  logic signed [31:0] a_z = '0;
  logic signed [31:0] b_x = '0;
  logic signed [31:0] b_y = '0;
  logic signed [31:0] b_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [30:0]        angle_rad;
  logic               zero_vector;

  // typed-in result travelling with the current beat
  logic          row_known = 1'b0;
  angle_result_t row_result = '0;

  angle_result_t expected_angles [$];
  int hold_requests = 0;
  int mismatches = 0;
  int pairs_in = 0;
  int results_out = 0;
  int zero_hits = 0;
  int null_hits = 0;
  int quarter_hits [4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;
  int burst_left = 0;
  int gapless_left = 0;

  vector_angle_atan2_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .a_x         (a_x),
    .a_y         (a_y),
    .a_z         (a_z),
    .b_x         (b_x),
    .b_y         (b_y),
    .b_z         (b_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .angle_rad   (angle_rad),
    .zero_vector (zero_vector)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exact product of two q16.16 values as sign and magnitude
  function automatic signed_mag_t sm_product(input logic signed [31:0] p,
                                             input logic signed [31:0] q);
    signed_mag_t r;
    logic [63:0] mp;
    logic [63:0] mq;
    mp = p[31] ? -longint'(p) : longint'(p);
    mq = q[31] ? -longint'(q) : longint'(q);
    r.mag = mp * mq;
    r.neg = (p[31] != q[31]) && (r.mag != 0);
    return r;
  endfunction

  function automatic signed_mag_t sm_sum(input signed_mag_t p, input signed_mag_t q);
    signed_mag_t r;
    if (p.neg == q.neg) begin
      r.mag = p.mag + q.mag;
      r.neg = p.neg;
    end else if (p.mag >= q.mag) begin
      r.mag = p.mag - q.mag;
      r.neg = p.neg;
    end else begin
      r.mag = q.mag - p.mag;
      r.neg = q.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  // angle from base b to a: exact cross and dot, normalize, vectoring cordic
  function automatic angle_result_t predict_angle(
    input logic signed [31:0] ax, input logic signed [31:0] ay,
    input logic signed [31:0] az, input logic signed [31:0] bx,
    input logic signed [31:0] by, input logic signed [31:0] bz);
    angle_result_t res;
    signed_mag_t   cross_term;
    signed_mag_t   dot;
    signed_mag_t   back;
    logic [31:0]   turns;
    logic [63:0]   mx;
    logic [63:0]   my;
    logic [63:0]   big;
    logic [63:0]   scaled;
    logic          yneg;
    longint        x;
    longint        y;
    longint        xs;
    longint        ys;
    int            len;
    res = '0;
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
      res.zero = 1'b1;
    end else begin
      back = sm_product(by, ax);
      back.neg = !back.neg && (back.mag != 0);
      cross_term = sm_sum(sm_product(bx, ay), back);
      dot = sm_sum(sm_sum(sm_product(ax, bx), sm_product(ay, by)), sm_product(az, bz));
      if (cross_term.mag != 0 || dot.mag != 0) begin
        turns = '0;
        mx = dot.mag;
        my = cross_term.mag;
        yneg = cross_term.neg;
        // negative dot: start half a turn around
        if (dot.neg) begin
          turns = 32'h8000_0000;
          yneg = !yneg && (my != 0);
        end
        big = (mx > my) ? mx : my;
        len = 0;
        while (len < 64 && (big >> len) != 0) len++;
        if (len > NORM_WIDTH) begin
          mx = mx >> (len - NORM_WIDTH);
          my = my >> (len - NORM_WIDTH);
        end else begin
          mx = mx << (NORM_WIDTH - len);
          my = my << (NORM_WIDTH - len);
        end
        x = longint'(mx);
        y = yneg ? -longint'(my) : longint'(my);
        for (int i = 0; i < ANGLE_STEPS && i < 32; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y < 0) begin
            x = x - ys;
            y = y + xs;
            turns = turns - ATAN_STEP_TURNS[i];
          end else begin
            x = x + ys;
            y = y - xs;
            turns = turns + ATAN_STEP_TURNS[i];
          end
        end
        // binary angle to q3.28 radians, rounded half up
        scaled = {32'd0, turns} * FULL_TURN_Q28 + 64'h8000_0000;
        res.angle = scaled[62:32];
      end
    end
    return res;
  endfunction

  function automatic logic signed [31:0] pick_component(input comp_kind_t kind);
    logic signed [31:0] v;
    case (kind)
      COMP_SMALL: begin
        v = $signed($urandom_range(0, 2097152)) - 1048576;
      end
      COMP_CORNER: begin
        case ($urandom_range(0, 5))
          0: v = MIN_Q;
          1: v = MAX_Q;
          2: v = 0;
          3: v = 1;
          4: v = -1;
          default: v = $urandom;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // random pair: mostly free content, some zero vectors, null and flat cases
  function automatic pair_row_t build_pair();
    pair_row_t  r;
    comp_kind_t kind;
    int         roll;
    int         xa;
    int         ya;
    int         za;
    int         kk;
    r = '0;
    roll = $urandom_range(0, 99);
    if (roll < 87) begin
      kind = (roll < 55) ? COMP_FULL : (roll < 70) ? COMP_SMALL : COMP_CORNER;
      if (roll >= 82) kind = COMP_FULL;
      r.ax = pick_component(kind);
      r.ay = pick_component(kind);
      r.az = pick_component(kind);
      r.bx = pick_component(kind);
      r.by = pick_component(kind);
      r.bz = pick_component(kind);
      // zero vector on one side or both
      if (roll >= 82) begin
        case ($urandom_range(0, 2))
          0: begin
            r.ax = 0;
            r.ay = 0;
            r.az = 0;
          end
          1: begin
            r.bx = 0;
            r.by = 0;
            r.bz = 0;
          end
          default: r = '0;
        endcase
      end
    end else begin
      // b parallel to a in the xy view, so the cross term is zero
      xa = $signed($urandom_range(0, 2000)) - 1000;
      ya = $signed($urandom_range(0, 2000)) - 1000;
      kk = $signed($urandom_range(0, 200)) - 100;
      r.ax = xa;
      r.ay = ya;
      r.bx = kk * xa;
      r.by = kk * ya;
      if (roll < 92) begin
        // z terms cancel the planar dot as well
        za = ($urandom_range(0, 1) == 1) ? 1 : -1;
        r.az = za;
        r.bz = -za * kk * (xa * xa + ya * ya);
      end else begin
        r.az = $signed($urandom_range(0, 2000)) - 1000;
        r.bz = $signed($urandom_range(0, 2000)) - 1000;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTED) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_result(input logic [30:0] got_angle, input logic got_zero);
    angle_result_t want;
    logic [63:0]   quarter;
    if (expected_angles.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing pending, angle_rad %0d zero_vector %0b",
                                got_angle, got_zero));
    end else begin
      want = expected_angles.pop_front();
      if (got_angle !== want.angle)
        report_mismatch($sformatf("result %0d angle_rad got %0d expected %0d",
                                  results_out, got_angle, want.angle));
      if (got_zero !== want.zero)
        report_mismatch($sformatf("result %0d zero_vector got %0b expected %0b",
                                  results_out, got_zero, want.zero));
      results_out++;
      if (want.zero) begin
        zero_hits++;
      end else if (want.angle == 0) begin
        null_hits++;
      end else begin
        quarter = ({33'd0, want.angle} * 64'd4) / FULL_TURN_Q28;
        quarter_hits[(quarter > 3) ? 3 : int'(quarter)]++;
      end
    end
  endtask

  // result beats are checked first, then the accepted input beat is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_result(angle_rad, zero_vector);
      if (in_valid && in_ready) begin
        expected_angles.push_back(row_known ? row_result
                                            : predict_angle(a_x, a_y, a_z, b_x, b_y, b_z));
        pairs_in++;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               QUIET_LIMIT, expected_angles.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: changing stall patterns, long hold-off on request
  initial begin : receiver
    stall_pattern_t mode;
    int             holds_served;
    int             mode_left;
    int             phase;
    mode = TAKE_ALL;
    holds_served = 0;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = stall_pattern_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          TAKE_ALL: out_ready <= 1'b1;
          TAKE_HALF: out_ready <= ($urandom_range(0, 1) == 1);
          TAKE_EVERY_FOURTH: out_ready <= (phase % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // present one pair and hold it until the beat is taken
  task automatic offer_pair(input pair_row_t r);
    in_valid <= 1'b1;
    a_x <= r.ax;
    a_y <= r.ay;
    a_z <= r.az;
    b_x <= r.bx;
    b_y <= r.by;
    b_z <= r.bz;
    row_known <= r.known;
    row_result <= '{angle: r.angle, zero: r.zero};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender bursts of random length with random gaps in between
  task automatic pace_sender();
    int gap;
    if (gapless_left > 0) begin
      gapless_left--;
    end else begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                 : $urandom_range(1, 30);
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int k = 0; k < N_DIRECTED; k++) begin
      pace_sender();
      offer_pair(DIRECTED_PAIRS[k]);
    end
    drain_results();

    // random pairs, with two long receiver hold-offs and one full pause
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == HOLD_FIRST_AT || n == HOLD_SECOND_AT) begin
        hold_requests <= hold_requests + 1;
        gapless_left = 90;
      end
      if (n == PAUSE_AT) drain_results();
      pace_sender();
      offer_pair(build_pair());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d vector pairs (%0d directed) and %0d results, %0d hold-offs",
             pairs_in, N_DIRECTED, results_out, hold_requests);
    $display("zero-vector %0d, null-angle %0d, quarter turns hit %0d/%0d/%0d/%0d",
             zero_hits, null_hits, quarter_hits[0], quarter_hits[1],
             quarter_hits[2], quarter_hits[3]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/vaa_pkg.sv
rtl/core/vaa_cordic.sv
rtl/core/vector_angle_atan2_unit.sv
verif/tb_top.sv
